// ===== rtl/lgs_pkg.sv =====
// Shared types, constants and the Life rule for the generation stencil.
// No dependencies; imported by the stencil top level.
package lgs_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int GW_BITS  = 11;
    localparam int GH_BITS  = 13;
    localparam int CFG_BITS = 13;
    localparam int IDX_BITS = 1;

    localparam logic [GW_BITS-1:0] GW_RESET = 11'd64;
    localparam logic [GH_BITS-1:0] GH_RESET = 13'd64;

    typedef enum logic [IDX_BITS-1:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam int OQ_DEPTH = 8;
    localparam int OQ_PW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic last;
        logic ns;
    } res_t;

    // window bit 3*col + row; row 0 top, col 0 left; centre is bit 4
    function automatic logic life_next(input logic [8:0] win);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) n = n + {3'd0, win[k]};
        end
        return (n == 4'd3) || (win[4] && n == 4'd2);
    endfunction

endpackage

// ===== rtl/lgs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lgs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/life_generation_stencil_top.sv =====
// Life generation stencil, B3/S23. Throughput one cell per cycle; the two results at the last
// column are absorbed by the result queue, so outside the clearing pass s_tready drops only
// while m_tready holds off. Row store is one RAM, read and written once per cycle, with
// forwarding for single-column grids.
// Reset (aresetn low, synchronous) starts a clearing pass over every row store entry,
// during which s_tready is low; configuration writes are taken.
module life_generation_stencil_top #(
    parameter int MAX_WIDTH  = lgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lgs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [lgs_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [lgs_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] cell_state
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [0] next_state
    output logic                          m_tlast
);

    import lgs_pkg::*;

    localparam int CNW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RNW = $clog2(MAX_HEIGHT + 1);
    localparam logic [CNW-1:0] COL_LAST = CNW'(MAX_WIDTH - 1);

    // configuration
    logic [GW_BITS-1:0] gw_reg;
    logic [GH_BITS-1:0] gh_reg;
    logic [GW_BITS-1:0] eff_w;
    logic [GH_BITS-1:0] eff_h;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg <= GW_RESET;
            gh_reg <= GH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GRID_WIDTH:  gw_reg <= cfg_wdata[GW_BITS-1:0];
                REG_GRID_HEIGHT: gh_reg <= cfg_wdata[GH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (gw_reg == '0) eff_w = GW_BITS'(1);
        else if (32'(gw_reg) > MAX_WIDTH) eff_w = GW_BITS'(MAX_WIDTH);
        else eff_w = gw_reg;
        if (gh_reg == '0) eff_h = GH_BITS'(1);
        else if (32'(gh_reg) > MAX_HEIGHT) eff_h = GH_BITS'(MAX_HEIGHT);
        else eff_h = gh_reg;
    end

    // row store clearing pass
    logic           clearing_reg;
    logic [CNW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clearing_reg) begin
            clr_addr_reg <= clr_addr_reg + CNW'(1);
            if (clr_addr_reg == COL_LAST) clearing_reg <= 1'b0;
        end
    end

    // stage A: accept, counters, RAM read
    logic           in_acc;
    logic [CNW-1:0] col_reg, col_next;
    logic [RNW-1:0] row_reg, row_next;
    logic           last_col, padding, cur;

    assign in_acc   = s_tvalid && s_tready;
    assign last_col = (32'(col_reg) + 32'd1) >= 32'(eff_w);
    assign padding  = 32'(row_reg) >= 32'(eff_h);
    assign cur      = padding ? 1'b0 : s_tdata[0];

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc) begin
            if (last_col) begin
                col_next = '0;
                row_next = padding ? '0 : row_reg + RNW'(1);
            end else begin
                col_next = col_reg + CNW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // RAM
    logic           ram_we;
    logic [CNW-1:0] ram_waddr;
    logic [1:0]     ram_wdata;
    logic [1:0]     ram_rdata;
    logic [1:0]     st_wdata;

    lgs_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // stage B registers
    logic           p1_valid_reg;
    logic [CNW-1:0] p1_col_reg;
    logic           p1_cur_reg, p1_row0_reg, p1_last_col_reg, p1_pad_reg;
    logic           p1_fwd_reg;
    logic [1:0]     p1_fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= in_acc;
        end
        p1_col_reg      <= col_reg;
        p1_cur_reg      <= cur;
        p1_row0_reg     <= (row_reg == '0);
        p1_last_col_reg <= last_col;
        p1_pad_reg      <= padding;
        p1_fwd_reg      <= ram_we && (ram_waddr == col_reg);
        p1_fwd_data_reg <= ram_wdata;
    end

    // stage B: row store update, window, rule
    logic [1:0] st_old;
    logic       mid, top;
    logic [8:0] win_reg, win1, win2;
    logic       res1, res2, res1_v, res2_v;

    assign st_old   = p1_fwd_reg ? p1_fwd_data_reg : ram_rdata;
    assign mid      = p1_row0_reg ? 1'b0 : st_old[0];
    assign top      = p1_row0_reg ? 1'b0 : st_old[1];
    assign st_wdata = {mid, p1_cur_reg};
    assign win1     = ((p1_col_reg == '0) ? 9'd0 : (win_reg >> 3)) |
                      {p1_cur_reg, mid, top, 6'd0};
    assign win2     = win1 >> 3;
    assign res1     = life_next(win1);
    assign res2     = life_next(win2);
    assign res1_v   = p1_valid_reg && !p1_row0_reg && (p1_col_reg != '0);
    assign res2_v   = p1_valid_reg && !p1_row0_reg && p1_last_col_reg;

    assign ram_we    = clearing_reg || p1_valid_reg;
    assign ram_waddr = clearing_reg ? clr_addr_reg : p1_col_reg;
    assign ram_wdata = clearing_reg ? 2'b00 : st_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (p1_valid_reg) begin
            win_reg <= win1;
        end
    end

    // result queue
    res_t             oq_reg [OQ_DEPTH];
    logic [OQ_PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OQ_CW-1:0] cnt_reg;
    logic             pop;
    logic [1:0]       n_push;
    logic [OQ_PW-1:0] second_ptr;

    assign pop        = m_tvalid && m_tready;
    assign n_push     = {1'b0, res1_v} + {1'b0, res2_v};
    assign second_ptr = res1_v ? wr_ptr_reg + OQ_PW'(1) : wr_ptr_reg;

    always_ff @(posedge aclk) begin
        if (res1_v) oq_reg[wr_ptr_reg] <= '{last: 1'b0, ns: res1};
        if (res2_v) oq_reg[second_ptr] <= '{last: p1_pad_reg, ns: res2};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + OQ_PW'(n_push);
            rd_ptr_reg <= rd_ptr_reg + OQ_PW'(pop);
            cnt_reg    <= cnt_reg + OQ_CW'(n_push) - OQ_CW'(pop);
        end
    end

    assign s_tready = !clearing_reg &&
                      ((OQ_CW + 1)'(cnt_reg) + (p1_valid_reg ? (OQ_CW + 1)'(2) : '0)
                       + (OQ_CW + 1)'(2) <= (OQ_CW + 1)'(OQ_DEPTH));

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {7'd0, oq_reg[rd_ptr_reg].ns};
    assign m_tlast  = oq_reg[rd_ptr_reg].last;

endmodule
